// ===== rtl/cstc_pkg.sv =====
// cstc_pkg: shared types and constants for the charset table classifier
// depends on nothing; used by cstc_accum and charset_table_classifier
package cstc_pkg;

  typedef enum logic [1:0] {
    FAM_ASCII   = 2'd0,
    FAM_EBCDIC  = 2'd1,
    FAM_UNKNOWN = 2'd2
  } fam_t;

  typedef enum logic {
    FUNC_ENTRY  = 1'b0,
    FUNC_FINISH = 1'b1
  } func_t;

  localparam logic [1:0] KIND_ROUNDTRIP = 2'd0;

  // private use ranges
  localparam logic [23:0] PUA_BMP_LO = 24'h00e000;
  localparam logic [23:0] PUA_BMP_HI = 24'h00f8ff;
  localparam logic [23:0] PUA_SUP_LO = 24'h0f0000;
  localparam logic [23:0] PUA_SUP_HI = 24'h10ffff;

  localparam logic [6:0] ASCII_GRAPHIC_COUNT = 7'd94;
  localparam logic [6:0] ASCII_COUNT_MAX     = 7'd127;

  localparam logic [15:0] DBCS_MIN_RESET = 16'hffff;

  typedef struct packed {
    logic        func;
    logic [23:0] code_point;
    logic [1:0]  fallback_kind;
    logic [31:0] cp_bytes;
  } req_t;

  typedef struct packed {
    logic       family_error;
    logic       charset_family;
    logic [2:0] min_len;
    logic [2:0] max_len;
    logic       uses_private_area;
    logic       lf_variant;
    logic       ascii_variant;
    logic       control_variant;
    logic       sub_variant;
    logic       seven_bit;
  } rsp_t;

endpackage

// ===== rtl/cstc_accum.sv =====
// cstc_accum: running table statistics, one entry per cycle, and final report
// depends on cstc_pkg
module cstc_accum (
  input  logic          clk,
  input  logic          rst,
  input  logic          entry_en,
  input  logic          finish_en,
  input  cstc_pkg::req_t item,
  output cstc_pkg::rsp_t result
);

  logic [2:0]     min_length, min_length_next;
  logic [2:0]     max_length, max_length_next;
  logic [15:0]    min_double, min_double_next;
  logic [15:0]    max_double, max_double_next;
  logic [31:0]    ored_bytes, ored_bytes_next;
  logic [6:0]     ascii_count, ascii_count_next;
  cstc_pkg::fam_t family_guess, family_next;
  logic           private_seen, private_next;
  logic           lf_flag, lf_next;
  logic           ascii_flag, ascii_next;
  logic           control_flag, control_next;
  logic           sub_flag, sub_next;

  logic [23:0] u;
  logic [31:0] b;
  logic [2:0]  len;
  logic        roundtrip;
  logic        is_graphic;
  logic        is_control;
  logic        identity;
  logic        sub_case;

  // entry update
  always_comb begin
    u          = item.code_point;
    b          = item.cp_bytes;
    roundtrip  = (item.fallback_kind == cstc_pkg::KIND_ROUNDTRIP);
    identity   = ({8'd0, u} == b);
    is_graphic = (u >= 24'h21) && (u <= 24'h7e);
    is_control = (u < 24'h20) || (u == 24'h7f);
    sub_case   = ((u == 24'h1a) && (b == 32'h7f)) ||
                 ((u == 24'h1c) && (b == 32'h1a)) ||
                 ((u == 24'h7f) && (b == 32'h1c));

    min_length_next  = min_length;
    max_length_next  = max_length;
    min_double_next  = min_double;
    max_double_next  = max_double;
    ascii_count_next = ascii_count;
    family_next      = family_guess;
    private_next     = private_seen;
    lf_next          = lf_flag;
    ascii_next       = ascii_flag;
    control_next     = control_flag;
    sub_next         = sub_flag;
    ored_bytes_next  = ored_bytes | b;

    if (b[31:8] == 24'd0) begin
      len = 3'd1;
    end else if (b[31:16] == 16'd0) begin
      len = 3'd2;
      if (b[15:0] < min_double) min_double_next = b[15:0];
      if (b[15:0] > max_double) max_double_next = b[15:0];
    end else if (b[31:24] == 8'd0) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    if (len < min_length) min_length_next = len;
    if (len > max_length) max_length_next = len;

    if (((u >= cstc_pkg::PUA_BMP_LO) && (u <= cstc_pkg::PUA_BMP_HI)) ||
        ((u >= cstc_pkg::PUA_SUP_LO) && (u <= cstc_pkg::PUA_SUP_HI))) begin
      private_next = 1'b1;
    end

    if (roundtrip) begin
      if (u == 24'h41) begin
        if (b == 32'h41) family_next = cstc_pkg::FAM_ASCII;
        else if (b == 32'hc1) family_next = cstc_pkg::FAM_EBCDIC;
      end else if (u == 24'h0a) begin
        if (b == 32'h0a) begin
          family_next = cstc_pkg::FAM_ASCII;
        end else if (b == 32'h25) begin
          family_next = cstc_pkg::FAM_EBCDIC;
          lf_next     = 1'b0;
        end else if (b == 32'h15) begin
          family_next = cstc_pkg::FAM_EBCDIC;
          lf_next     = 1'b1;
        end
      end

      if (is_graphic) begin
        if (identity) begin
          if (ascii_count < cstc_pkg::ASCII_COUNT_MAX) ascii_count_next = ascii_count + 7'd1;
        end else begin
          ascii_next = 1'b1;
        end
      end else if (is_control && !identity) begin
        if (sub_case) begin
          family_next = cstc_pkg::FAM_ASCII;
          sub_next    = 1'b1;
        end else begin
          control_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || finish_en) begin
      min_length   <= 3'd4;
      max_length   <= 3'd0;
      min_double   <= cstc_pkg::DBCS_MIN_RESET;
      max_double   <= 16'd0;
      ored_bytes   <= 32'd0;
      ascii_count  <= 7'd0;
      family_guess <= cstc_pkg::FAM_UNKNOWN;
      private_seen <= 1'b0;
      lf_flag      <= 1'b0;
      ascii_flag   <= 1'b0;
      control_flag <= 1'b0;
      sub_flag     <= 1'b0;
    end else if (entry_en) begin
      min_length   <= min_length_next;
      max_length   <= max_length_next;
      min_double   <= min_double_next;
      max_double   <= max_double_next;
      ored_bytes   <= ored_bytes_next;
      ascii_count  <= ascii_count_next;
      family_guess <= family_next;
      private_seen <= private_next;
      lf_flag      <= lf_next;
      ascii_flag   <= ascii_next;
      control_flag <= control_next;
      sub_flag     <= sub_next;
    end
  end

  // final rules
  cstc_pkg::fam_t fam;
  cstc_pkg::fam_t dbcs_fam;
  logic           err;
  logic           sbcs;

  always_comb begin
    if (((min_double >= 16'h2020) && (min_double <= 16'h217e) && (max_double <= 16'h7e7e)) ||
        ((min_double >= 16'ha0a0) && (min_double <= 16'ha1fe) && (max_double <= 16'hfefe)) ||
        ((min_double >= 16'h8140) && (min_double <= 16'h81fe) && (max_double <= 16'hfefe))) begin
      dbcs_fam = cstc_pkg::FAM_ASCII;
    end else if (((min_double == 16'h4040) ||
                  ((min_double >= 16'h4141) && (min_double <= 16'h41fe))) &&
                 (max_double <= 16'hfefe)) begin
      dbcs_fam = cstc_pkg::FAM_EBCDIC;
    end else begin
      dbcs_fam = cstc_pkg::FAM_UNKNOWN;
    end

    case (family_guess)
      cstc_pkg::FAM_ASCII:  fam = cstc_pkg::FAM_ASCII;
      cstc_pkg::FAM_EBCDIC: fam = cstc_pkg::FAM_EBCDIC;
      default: begin
        if ((min_length == 3'd2) && (max_length == 3'd2)) fam = dbcs_fam;
        else fam = cstc_pkg::FAM_UNKNOWN;
      end
    endcase

    err  = (fam == cstc_pkg::FAM_UNKNOWN);
    sbcs = (min_length == 3'd1);

    result.family_error      = err;
    result.charset_family    = (fam == cstc_pkg::FAM_EBCDIC);
    result.min_len           = min_length;
    result.max_len           = max_length;
    result.uses_private_area = private_seen;
    result.seven_bit         = (ored_bytes[31:7] == 25'd0);
    if ((fam == cstc_pkg::FAM_ASCII) && sbcs) begin
      result.ascii_variant   = ascii_flag || (ascii_count != cstc_pkg::ASCII_GRAPHIC_COUNT);
      result.control_variant = control_flag;
      result.sub_variant     = sub_flag;
    end else begin
      result.ascii_variant   = 1'b0;
      result.control_variant = 1'b0;
      result.sub_variant     = 1'b0;
    end
    result.lf_variant = (fam == cstc_pkg::FAM_EBCDIC) && sbcs && lf_flag;
  end

endmodule

// ===== rtl/charset_table_classifier.sv =====
// charset_table_classifier: top level, input register, accumulator and result register
// depends on cstc_pkg and cstc_accum
// an entry is folded into the running state in the cycle after its acceptance;
//   a finish passes through the input register and then the result register
// throughput: one transaction per cycle while no finish is blocked, set by the accumulator update;
//   a finish waits in the input register only while an earlier result is still held
// reset (rst, synchronous, active high) empties both registers and restores the state
module charset_table_classifier (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  cstc_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cstc_pkg::rsp_t rsp
);

  // input register
  logic           q_valid, q_valid_next;
  cstc_pkg::req_t q;

  // accumulator handshake
  logic           req_fire;
  logic           entry_fire;
  logic           finish_fire;
  logic           advance;
  cstc_pkg::rsp_t result;

  // an entry always drains; a finish needs the result register free (or leaving)
  assign entry_fire  = q_valid && (q.func == cstc_pkg::FUNC_ENTRY);
  assign finish_fire = q_valid && (q.func == cstc_pkg::FUNC_FINISH) &&
                       (!rsp_valid || !rsp_stall);
  assign advance     = entry_fire || finish_fire;

  // the input register stays open while a result waits, unless it holds a finish, so a new
  // transaction can be taken behind it
  assign req_stall = q_valid && !advance;
  assign req_fire  = req_valid && !req_stall;

  always_comb begin
    q_valid_next = q_valid;
    if (req_fire) q_valid_next = 1'b1;
    else if (advance) q_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      q_valid <= q_valid_next;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (req_fire) begin
      q <= req;
    end
  end

  cstc_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .entry_en  (entry_fire),
    .finish_en (finish_fire),
    .item      (q),
    .result    (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish_fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_fire) begin
      rsp <= result;
    end
  end

  // a finish always produces a result in the next cycle
  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    finish_fire |=> rsp_valid)
    else $error("finish did not produce a result");

  // a held result is never overwritten
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("held result changed");

  // the input side only stalls behind a blocked finish
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (q_valid && (q.func == cstc_pkg::FUNC_FINISH) && rsp_valid && rsp_stall))
    else $error("input stalled without a blocked finish");

  // the running state is cleared after a finish
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    finish_fire |=> ((result.min_len == 3'd4) && (result.max_len == 3'd0) &&
                     result.family_error))
    else $error("state not cleared after finish");

endmodule
